>>> hw/rtl/dpl_pkg.sv
// dpl_pkg: control word types, step addresses and the microcode rom of the divisor lister
// depends on nothing; used by divisor_and_prime_factor_lister
package dpl_pkg;

  localparam int unsigned STEP_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LIST_ALL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_PRIME = 2'd1;

  typedef enum logic [1:0] {
    W_NONE,
    W_IN,
    W_MOD,
    W_OUT
  } wait_e;

  typedef enum logic [3:0] {
    J_NEVER,
    J_ALWAYS,
    J_N_ZERO,
    J_ALL_OFF,
    J_PRIME_SKIP,
    J_REM_NZ,
    J_REM_Z,
    J_I_EQ_N,
    J_D_EQ_I
  } jcond_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_I_INC,
    OP_I_TWO,
    OP_D_TWO,
    OP_D_INC,
    OP_MOD_NI,
    OP_MOD_ID,
    OP_EMIT_ALL,
    OP_EMIT_PRIME,
    OP_FIN
  } op_e;

  typedef struct packed {
    wait_e             wt;
    jcond_e            jc;
    logic [STEP_W-1:0] tgt;
    op_e               op;
  } ctl_t;

  // step addresses
  localparam logic [STEP_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [STEP_W-1:0] ST_CHKN  = 5'd1;
  localparam logic [STEP_W-1:0] ST_CHKA  = 5'd2;
  localparam logic [STEP_W-1:0] ST_AMOD  = 5'd3;
  localparam logic [STEP_W-1:0] ST_AWAIT = 5'd4;
  localparam logic [STEP_W-1:0] ST_AEMIT = 5'd5;
  localparam logic [STEP_W-1:0] ST_ANEXT = 5'd6;
  localparam logic [STEP_W-1:0] ST_AINC  = 5'd7;
  localparam logic [STEP_W-1:0] ST_PINIT = 5'd8;
  localparam logic [STEP_W-1:0] ST_PI2   = 5'd9;
  localparam logic [STEP_W-1:0] ST_PMOD  = 5'd10;
  localparam logic [STEP_W-1:0] ST_PWAIT = 5'd11;
  localparam logic [STEP_W-1:0] ST_PD2   = 5'd12;
  localparam logic [STEP_W-1:0] ST_DCHK  = 5'd13;
  localparam logic [STEP_W-1:0] ST_DMOD  = 5'd14;
  localparam logic [STEP_W-1:0] ST_DWAIT = 5'd15;
  localparam logic [STEP_W-1:0] ST_DINC  = 5'd16;
  localparam logic [STEP_W-1:0] ST_PEMIT = 5'd17;
  localparam logic [STEP_W-1:0] ST_PNEXT = 5'd18;
  localparam logic [STEP_W-1:0] ST_PINC  = 5'd19;
  localparam logic [STEP_W-1:0] ST_FIN   = 5'd20;

  // microcode rom: wait condition, jump condition, jump target, datapath op
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t c;
    unique case (step)
      ST_IDLE:  c = '{wt: W_IN,   jc: J_NEVER,      tgt: ST_IDLE,  op: OP_LOAD};
      ST_CHKN:  c = '{wt: W_NONE, jc: J_N_ZERO,     tgt: ST_IDLE,  op: OP_NONE};
      ST_CHKA:  c = '{wt: W_NONE, jc: J_ALL_OFF,    tgt: ST_PINIT, op: OP_NONE};
      ST_AMOD:  c = '{wt: W_NONE, jc: J_NEVER,      tgt: ST_IDLE,  op: OP_MOD_NI};
      ST_AWAIT: c = '{wt: W_MOD,  jc: J_REM_NZ,     tgt: ST_ANEXT, op: OP_NONE};
      ST_AEMIT: c = '{wt: W_OUT,  jc: J_NEVER,      tgt: ST_IDLE,  op: OP_EMIT_ALL};
      ST_ANEXT: c = '{wt: W_NONE, jc: J_I_EQ_N,     tgt: ST_PINIT, op: OP_NONE};
      ST_AINC:  c = '{wt: W_NONE, jc: J_ALWAYS,     tgt: ST_AMOD,  op: OP_I_INC};
      ST_PINIT: c = '{wt: W_NONE, jc: J_PRIME_SKIP, tgt: ST_FIN,   op: OP_NONE};
      ST_PI2:   c = '{wt: W_NONE, jc: J_NEVER,      tgt: ST_IDLE,  op: OP_I_TWO};
      ST_PMOD:  c = '{wt: W_NONE, jc: J_NEVER,      tgt: ST_IDLE,  op: OP_MOD_NI};
      ST_PWAIT: c = '{wt: W_MOD,  jc: J_REM_NZ,     tgt: ST_PNEXT, op: OP_NONE};
      ST_PD2:   c = '{wt: W_NONE, jc: J_NEVER,      tgt: ST_IDLE,  op: OP_D_TWO};
      ST_DCHK:  c = '{wt: W_NONE, jc: J_D_EQ_I,     tgt: ST_PEMIT, op: OP_NONE};
      ST_DMOD:  c = '{wt: W_NONE, jc: J_NEVER,      tgt: ST_IDLE,  op: OP_MOD_ID};
      ST_DWAIT: c = '{wt: W_MOD,  jc: J_REM_Z,      tgt: ST_PNEXT, op: OP_NONE};
      ST_DINC:  c = '{wt: W_NONE, jc: J_ALWAYS,     tgt: ST_DCHK,  op: OP_D_INC};
      ST_PEMIT: c = '{wt: W_OUT,  jc: J_NEVER,      tgt: ST_IDLE,  op: OP_EMIT_PRIME};
      ST_PNEXT: c = '{wt: W_NONE, jc: J_I_EQ_N,     tgt: ST_FIN,   op: OP_NONE};
      ST_PINC:  c = '{wt: W_NONE, jc: J_ALWAYS,     tgt: ST_PMOD,  op: OP_I_INC};
      ST_FIN:   c = '{wt: W_OUT,  jc: J_ALWAYS,     tgt: ST_IDLE,  op: OP_FIN};
      default:  c = '{wt: W_NONE, jc: J_ALWAYS,     tgt: ST_IDLE,  op: OP_NONE};
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/divisor_and_prime_factor_lister.sv
// divisor_and_prime_factor_lister: top level, microcode sequencer and result registers
// depends on dpl_pkg and dpl_mod
//
// Takes one number n per item and lists, by trial division, first every divisor of n
// in ascending order (kind 0, when the CFG_LIST_ALL bit is set) and then every prime divisor
// in ascending order (kind 1, when the CFG_LIST_PRIME bit is set); the final result of an
// item has last set, and n = 0 gives no result. Input stall stays high from the item's
// acceptance until its run ends. All work goes through one serial remainder unit, one trial
// at a time, with sequencer steps around each trial: the divisor list tries every i from 1
// to n, and the prime list tries every i from 2 to n and tests each divisor it finds for
// primality by trial division from 2, a composite divisor adding only the trials up to its
// smallest factor. Results leave through one output register that is refilled while the
// sequencer keeps searching.
module divisor_and_prime_factor_lister #(
  parameter int unsigned VALUE_WIDTH = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic                            cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [VALUE_WIDTH-1:0]          number_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [VALUE_WIDTH-1:0]          divisor_o,
  output logic                            kind_o,
  output logic                            last_o
);

  import dpl_pkg::*;

  logic                   all_en_q;
  logic                   prime_en_q;
  logic [STEP_W-1:0]      step_q;
  logic [STEP_W-1:0]      step_d;
  logic [VALUE_WIDTH-1:0] n_q;
  logic [VALUE_WIDTH-1:0] i_q;
  logic [VALUE_WIDTH-1:0] d_q;
  logic                   pend_valid_q;
  logic [VALUE_WIDTH-1:0] pend_div_q;
  logic                   pend_kind_q;
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_div_q;
  logic                   out_kind_q;
  logic                   out_last_q;

  ctl_t                   cw;
  logic                   wait_ok;
  logic                   jump;
  logic                   out_free;
  logic                   do_emit;
  logic                   push;
  logic                   mod_start;
  logic                   mod_busy;
  logic [VALUE_WIDTH-1:0] mod_a;
  logic [VALUE_WIDTH-1:0] mod_b;
  logic [VALUE_WIDTH-1:0] rem;

  dpl_mod #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_a),
    .divisor_i  (mod_b),
    .busy_o     (mod_busy),
    .rem_o      (rem)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cw = ucode(step_q);

    unique case (cw.wt)
      W_NONE:  wait_ok = 1'b1;
      W_IN:    wait_ok = in_valid_i;
      W_MOD:   wait_ok = !mod_busy;
      W_OUT:   wait_ok = out_free;
      default: wait_ok = 1'b0;
    endcase

    unique case (cw.jc)
      J_NEVER:      jump = 1'b0;
      J_ALWAYS:     jump = 1'b1;
      J_N_ZERO:     jump = (n_q == '0);
      J_ALL_OFF:    jump = !all_en_q;
      J_PRIME_SKIP: jump = !prime_en_q || (n_q < VALUE_WIDTH'(2));
      J_REM_NZ:     jump = (rem != '0);
      J_REM_Z:      jump = (rem == '0);
      J_I_EQ_N:     jump = (i_q == n_q);
      J_D_EQ_I:     jump = (d_q == i_q);
      default:      jump = 1'b0;
    endcase

    if (!wait_ok) begin
      step_d = step_q;
    end else if (jump) begin
      step_d = cw.tgt;
    end else begin
      step_d = step_q + STEP_W'(1);
    end

    mod_start = wait_ok && (cw.op == OP_MOD_NI || cw.op == OP_MOD_ID);
    mod_a     = (cw.op == OP_MOD_ID) ? i_q : n_q;
    mod_b     = (cw.op == OP_MOD_ID) ? d_q : i_q;

    // a found divisor waits in the pending slot until the next one, or the end, decides last
    do_emit = wait_ok && (cw.op == OP_EMIT_ALL || cw.op == OP_EMIT_PRIME);
    push    = wait_ok && pend_valid_q
              && (cw.op == OP_EMIT_ALL || cw.op == OP_EMIT_PRIME || cw.op == OP_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_en_q     <= 1'b1;
      prime_en_q   <= 1'b1;
      step_q       <= ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LIST_ALL:   all_en_q   <= cfg_data_i;
          CFG_LIST_PRIME: prime_en_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (do_emit) begin
        pend_valid_q <= 1'b1;
      end else if (wait_ok && cw.op == OP_FIN) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wait_ok) begin
      unique case (cw.op)
        OP_LOAD: begin
          n_q <= number_i;
          i_q <= VALUE_WIDTH'(1);
        end
        OP_I_INC: i_q <= i_q + VALUE_WIDTH'(1);
        OP_I_TWO: i_q <= VALUE_WIDTH'(2);
        OP_D_TWO: d_q <= VALUE_WIDTH'(2);
        OP_D_INC: d_q <= d_q + VALUE_WIDTH'(1);
        OP_EMIT_ALL: begin
          pend_div_q  <= i_q;
          pend_kind_q <= 1'b0;
        end
        OP_EMIT_PRIME: begin
          pend_div_q  <= i_q;
          pend_kind_q <= 1'b1;
        end
        default: ;
      endcase
    end
    if (push) begin
      out_div_q  <= pend_div_q;
      out_kind_q <= pend_kind_q;
      out_last_q <= (cw.op == OP_FIN);
    end
  end

  assign in_stall_o  = (step_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign divisor_o   = out_div_q;
  assign kind_o      = out_kind_q;
  assign last_o      = out_last_q;

endmodule

>>> hw/rtl/dpl_mod.sv
// dpl_mod: serial restoring remainder unit, one quotient bit per cycle
// depends on nothing but its parameter
module dpl_mod #(
  parameter int unsigned VALUE_WIDTH = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   busy_o,
  output logic [VALUE_WIDTH-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH);

  logic                   busy_q;
  logic [CntW-1:0]        cnt_q;
  logic [VALUE_WIDTH-1:0] a_q;
  logic [VALUE_WIDTH-1:0] b_q;
  logic [VALUE_WIDTH-1:0] r_q;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;
  logic [VALUE_WIDTH-1:0] r_d;

  always_comb begin
    shifted = {r_q, a_q[VALUE_WIDTH-1]};
    diff    = shifted - {1'b0, b_q};
    // keep the shifted remainder when the subtract borrows
    r_d     = diff[VALUE_WIDTH] ? shifted[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(VALUE_WIDTH - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= dividend_i;
      b_q <= divisor_i;
      r_q <= '0;
    end else if (busy_q) begin
      a_q <= a_q << 1;
      r_q <= r_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = r_q;

endmodule
